>>> src/ppp_pkg.sv
// shared types and constants of the periodic probability predictor
// no dependencies
`default_nettype none
package ppp_pkg;

  localparam int unsigned AmpW    = 16;
  localparam int unsigned PhaseW  = 16;
  localparam int unsigned PeriodW = 20;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ProbW   = 16;
  localparam int unsigned ActW    = 9;
  localparam int unsigned EntryW  = AmpW + PhaseW + PeriodW;
  localparam int unsigned DivSteps = TimeW + 16;

  localparam logic CFG_BIAS   = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  localparam logic [15:0] BIAS_RESET = 16'd32768;
  localparam logic [15:0] PROB_MIN   = 16'd655;
  localparam logic [15:0] PROB_MAX   = 16'd64880;

  localparam logic signed [23:0] COEF_0 = -24'sd307;
  localparam logic signed [23:0] COEF_1 = 24'sd5223;
  localparam logic signed [23:0] COEF_2 = -24'sd42334;
  localparam logic signed [23:0] COEF_3 = 24'sd102944;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DIV, ST_ANGLE, ST_ZZ, ST_P1, ST_P2, ST_P3,
    ST_SINE, ST_ACC, ST_OUT
  } ppp_state_e;

  typedef enum logic [3:0] {
    STEP_NONE, STEP_LOAD, STEP_DIV_INIT, STEP_DIV, STEP_ANGLE, STEP_ZZ,
    STEP_P1, STEP_P2, STEP_P3, STEP_SINE, STEP_ACC, STEP_OUT
  } ppp_step_e;

  typedef struct packed {
    ppp_step_e step;
  } ppp_cmd_t;

endpackage
`default_nettype wire

>>> src/periodic_probability_predictor_core.sv
// periodic probability predictor: a write stores one component and never
// raises busy; a query covers n active components (a table read, a 48-step
// bit-serial period division, an angle step and 6 shared-multiplier steps
// each), one query at a time; valid_o strobes one cycle per result and the
// receiver cannot stall; reset clears control and valid_o and presets the
// bias; other registers and the table stay undefined until written
`default_nettype none
module periodic_probability_predictor_core #(
  parameter int unsigned MAX_COMPONENTS = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          operation_i,
  input  wire logic [7:0]                    entry_index_i,
  input  wire logic signed [ppp_pkg::AmpW-1:0] entry_amplitude_i,
  input  wire logic [ppp_pkg::PhaseW-1:0]    entry_phase_i,
  input  wire logic [ppp_pkg::PeriodW-1:0]   entry_period_i,
  input  wire logic [ppp_pkg::TimeW-1:0]     query_time_i,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [15:0]                   cfg_data_i,
  output logic [ppp_pkg::ProbW-1:0]          probability_o,
  output logic                               valid_o
);
  import ppp_pkg::*;

  localparam int unsigned AW = MAX_COMPONENTS > 1 ? $clog2(MAX_COMPONENTS) : 1;

  ppp_cmd_t cmd;
  logic [AW-1:0] raddr;
  logic [EntryW-1:0] rdata;
  logic we;

  assign we = start_i && !busy_o && operation_i == OP_WRITE
           && 32'(entry_index_i) < MAX_COMPONENTS;

  ppp_ram #(.WIDTH(EntryW), .DEPTH(MAX_COMPONENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(entry_index_i)),
    .wdata_i ({entry_amplitude_i, entry_phase_i, entry_period_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ppp_ctrl #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .raddr_o     (raddr),
    .busy_o      (busy_o)
  );

  ppp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .query_time_i  (query_time_i),
    .amp_i         (rdata[EntryW-1 -: AmpW]),
    .phase_i       (rdata[PeriodW +: PhaseW]),
    .period_i      (rdata[PeriodW-1:0]),
    .probability_o (probability_o),
    .valid_o       (valid_o)
  );
endmodule
`default_nettype wire

>>> src/ppp_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module ppp_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> src/ppp_ctrl.sv
// controller: sequences each query over the component table
// depends on ppp_pkg
`default_nettype none
module ppp_ctrl #(
  parameter int unsigned MAX_COMPONENTS = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic                  operation_i,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i,
  output ppp_pkg::ppp_cmd_t          cmd_o,
  output logic [(MAX_COMPONENTS > 1 ? $clog2(MAX_COMPONENTS) : 1)-1:0] raddr_o,
  output logic                       busy_o
);
  import ppp_pkg::*;

  localparam int unsigned AW = MAX_COMPONENTS > 1 ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_COMPONENTS + 1);

  ppp_state_e state_q, state_d;
  logic [ActW-1:0] active_q;
  logic [CW-1:0] comp_q, n_eff;
  logic [5:0] cnt_q;
  logic query;

  assign busy_o  = state_q != ST_IDLE;
  assign query   = start_i && !busy_o && operation_i == OP_PREDICT;
  assign n_eff   = (32'(active_q) > MAX_COMPONENTS) ? CW'(MAX_COMPONENTS) : CW'(active_q);
  assign raddr_o = AW'(comp_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (query) state_d = (n_eff == '0) ? ST_OUT : ST_READ;
      ST_READ:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == 6'(DivSteps - 1)) state_d = ST_ANGLE;
      ST_ANGLE: state_d = ST_ZZ;
      ST_ZZ:    state_d = ST_P1;
      ST_P1:    state_d = ST_P2;
      ST_P2:    state_d = ST_P3;
      ST_P3:    state_d = ST_SINE;
      ST_SINE:  state_d = ST_ACC;
      ST_ACC:   state_d = (CW'(comp_q + 1'b1) == n_eff) ? ST_OUT : ST_READ;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.step = STEP_NONE;
    case (state_q)
      ST_IDLE:  if (query) cmd_o.step = STEP_LOAD;
      ST_READ:  cmd_o.step = STEP_DIV_INIT;
      ST_DIV:   cmd_o.step = STEP_DIV;
      ST_ANGLE: cmd_o.step = STEP_ANGLE;
      ST_ZZ:    cmd_o.step = STEP_ZZ;
      ST_P1:    cmd_o.step = STEP_P1;
      ST_P2:    cmd_o.step = STEP_P2;
      ST_P3:    cmd_o.step = STEP_P3;
      ST_SINE:  cmd_o.step = STEP_SINE;
      ST_ACC:   cmd_o.step = STEP_ACC;
      ST_OUT:   cmd_o.step = STEP_OUT;
      default:  cmd_o.step = STEP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      active_q <= '0;
      comp_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CFG_ACTIVE) begin
        active_q <= cfg_data_i[ActW-1:0];
      end
      if (query) begin
        comp_q <= '0;
      end else if (state_q == ST_ACC) begin
        comp_q <= CW'(comp_q + 1'b1);
      end
      if (state_q == ST_DIV) begin
        cnt_q <= 6'(cnt_q + 1'b1);
      end else begin
        cnt_q <= '0;
      end
    end
  end
endmodule
`default_nettype wire

>>> src/ppp_dpath.sv
// datapath: period division, fixed point cosine, accumulate and clamp
// depends on ppp_pkg
`default_nettype none
module ppp_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ppp_pkg::ppp_cmd_t           cmd_i,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [15:0]                 cfg_data_i,
  input  wire logic [ppp_pkg::TimeW-1:0]   query_time_i,
  input  wire logic signed [ppp_pkg::AmpW-1:0] amp_i,
  input  wire logic [ppp_pkg::PhaseW-1:0]  phase_i,
  input  wire logic [ppp_pkg::PeriodW-1:0] period_i,
  output logic [ppp_pkg::ProbW-1:0]        probability_o,
  output logic                             valid_o
);
  import ppp_pkg::*;

  logic [15:0] bias_q;
  logic [TimeW-1:0] time_q;
  logic [DivSteps-1:0] dvd_q;
  logic [PeriodW-1:0] rem_q, peff;
  logic [PeriodW:0] rem_sh;
  logic [15:0] quot_q, ang, bang;
  logic [16:0] z_q, z2_q;
  logic neg_q;
  logic signed [19:0] p_q, mul_a, mul_b;
  logic signed [39:0] prod;
  logic signed [23:0] fs;
  logic signed [17:0] cos_q;
  logic signed [43:0] acc_q;
  logic signed [27:0] res;
  logic [16:0] s_val;

  assign peff   = (period_i == '0) ? PeriodW'(1) : period_i;
  assign rem_sh = {rem_q, dvd_q[DivSteps-1]};
  assign ang    = quot_q - phase_i;
  assign bang   = ang + 16'd16384;
  assign prod   = mul_a * mul_b;
  assign fs     = 24'(prod >>> 16);
  assign res    = 28'(acc_q >>> 16);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      STEP_ZZ:   begin mul_a = 20'(z_q);   mul_b = 20'(z_q);  end
      STEP_P1:   begin mul_a = 20'(COEF_0); mul_b = 20'(z2_q); end
      STEP_P2,
      STEP_P3:   begin mul_a = p_q;        mul_b = 20'(z2_q); end
      STEP_SINE: begin mul_a = p_q;        mul_b = 20'(z_q);  end
      STEP_ACC:  begin mul_a = 20'(amp_i); mul_b = 20'(cos_q); end
      default:   begin mul_a = '0;         mul_b = '0;        end
    endcase
  end

  always_comb begin
    if (fs < 0) begin
      s_val = '0;
    end else if (fs > 24'sd65536) begin
      s_val = 17'd65536;
    end else begin
      s_val = 17'(fs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q  <= BIAS_RESET;
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.step == STEP_OUT;
      if (cfg_we_i && cfg_idx_i == CFG_BIAS) begin
        bias_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      STEP_LOAD: begin
        time_q <= query_time_i;
        acc_q  <= 44'({1'b0, bias_q, 16'd0});
      end
      STEP_DIV_INIT: begin
        rem_q <= '0;
        dvd_q <= {time_q, 16'd0};
      end
      STEP_DIV: begin
        dvd_q <= dvd_q << 1;
        if (rem_sh >= {1'b0, peff}) begin
          rem_q  <= PeriodW'(rem_sh - {1'b0, peff});
          quot_q <= {quot_q[14:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[PeriodW-1:0];
          quot_q <= {quot_q[14:0], 1'b0};
        end
      end
      STEP_ANGLE: begin
        z_q   <= bang[14] ? 17'((17'd16384 - 17'(bang[13:0])) << 2) : {1'b0, bang[13:0], 2'b00};
        neg_q <= bang[15];
      end
      STEP_ZZ:   z2_q <= prod[32:16];
      STEP_P1:   p_q <= 20'(COEF_1 + fs);
      STEP_P2:   p_q <= 20'(COEF_2 + fs);
      STEP_P3:   p_q <= 20'(COEF_3 + fs);
      STEP_SINE: cos_q <= neg_q ? -18'(s_val) : 18'(s_val);
      STEP_ACC:  acc_q <= acc_q + (44'(prod) <<< 1);
      STEP_OUT: begin
        if (res > $signed(28'(PROB_MAX))) begin
          probability_o <= PROB_MAX;
        end else if (res < $signed(28'(PROB_MIN))) begin
          probability_o <= PROB_MIN;
        end else begin
          probability_o <= res[15:0];
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
